FILE: sv/smx_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smx_pkg
// Shared constants, codes and controller/datapath interface types for the
// SplitMix64 random source.
// ----------------------------------------------------------------------------
package smx_pkg;

   // Generator constants
   localparam logic [63:0] GOLDEN_INC = 64'h9E3779B97F4A7C15;
   localparam logic [63:0] MIX_MUL_A  = 64'hBF58476D1CE4E5B9;
   localparam logic [63:0] MIX_MUL_B  = 64'h94D049BB133111EB;

   localparam int WORD_W  = 64;
   localparam int HALF_W  = 32;
   localparam int CNT_W   = 6;   // bit counter of the remainder unit

   // Request kinds
   typedef enum logic [1:0] {
      REQ_WORD  = 2'd0,
      REQ_UPPER = 2'd1,
      REQ_BELOW = 2'd2,
      REQ_BOOL  = 2'd3
   } req_op_type;

   // Datapath operations
   typedef enum logic [3:0] {
      DP_NONE,
      DP_CAPTURE,
      DP_ADVANCE,
      DP_MUL_LL,
      DP_MUL_HL,
      DP_MUL_LH,
      DP_MUL_SUM,
      DP_XSH27,
      DP_FINAL,
      DP_DIV_STEP,
      DP_TAKE_REM,
      DP_ZERO,
      DP_PUBLISH
   } dp_op_type;

   // Controller states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_ZERO,
      ST_ADV,
      ST_MA_LL,
      ST_MA_HL,
      ST_MA_LH,
      ST_MA_SUM,
      ST_XS27,
      ST_MB_LL,
      ST_MB_HL,
      ST_MB_LH,
      ST_MB_SUM,
      ST_FIN,
      ST_DIV,
      ST_REM
   } ctrl_state_type;

   // Controller to datapath
   typedef struct packed {
      dp_op_type dp_op;
      logic      load_seed;
      logic      use_mul_b;
   } smx_cmd_type;

   // Datapath to controller
   typedef struct packed {
      req_op_type op;
      logic       bound_zero;
      logic       div_last;
   } smx_stat_type;

endpackage

FILE: sv/smx_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smx_ctrl
// Sequencer for one request: state advance, two mixing multiplies of three
// partial products each, optional bit-serial remainder, result hand-off.
// ----------------------------------------------------------------------------
module smx_ctrl
   import smx_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic         csr_valid,
   output logic         csr_ready,
   output smx_cmd_type  cmd,
   input  smx_stat_type stat
);

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           slot_free;
   logic           publish;

   // Output register is free when empty or being drained this cycle
   assign slot_free = !rsp_valid_ff || rsp_tready;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_tvalid) state_in = ST_CHECK;
         ST_CHECK: begin
            if (stat.op == REQ_BELOW && stat.bound_zero) state_in = ST_ZERO;
            else                                         state_in = ST_ADV;
         end
         ST_ZERO:   state_in = ST_REM;
         ST_ADV:    state_in = ST_MA_LL;
         ST_MA_LL:  state_in = ST_MA_HL;
         ST_MA_HL:  state_in = ST_MA_LH;
         ST_MA_LH:  state_in = ST_MA_SUM;
         ST_MA_SUM: state_in = ST_XS27;
         ST_XS27:   state_in = ST_MB_LL;
         ST_MB_LL:  state_in = ST_MB_HL;
         ST_MB_HL:  state_in = ST_MB_LH;
         ST_MB_LH:  state_in = ST_MB_SUM;
         ST_MB_SUM: state_in = ST_FIN;
         ST_FIN: begin
            if (stat.op == REQ_BELOW) state_in = ST_DIV;
            else                      state_in = ST_REM;
         end
         ST_DIV:    if (stat.div_last) state_in = ST_REM;
         ST_REM:    if (slot_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Outputs and datapath commands
   always_comb begin
      cmd.dp_op     = DP_NONE;
      cmd.load_seed = 1'b0;
      cmd.use_mul_b = 1'b0;
      publish       = 1'b0;
      req_tready    = 1'b0;
      csr_ready     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready    = 1'b1;
            csr_ready     = 1'b1;
            cmd.load_seed = csr_valid;
            if (req_tvalid) cmd.dp_op = DP_CAPTURE;
         end
         ST_ZERO:   cmd.dp_op = DP_ZERO;
         ST_ADV:    cmd.dp_op = DP_ADVANCE;
         ST_MA_LL:  cmd.dp_op = DP_MUL_LL;
         ST_MA_HL:  cmd.dp_op = DP_MUL_HL;
         ST_MA_LH:  cmd.dp_op = DP_MUL_LH;
         ST_MA_SUM: cmd.dp_op = DP_MUL_SUM;
         ST_XS27:   cmd.dp_op = DP_XSH27;
         ST_MB_LL: begin
            cmd.dp_op     = DP_MUL_LL;
            cmd.use_mul_b = 1'b1;
         end
         ST_MB_HL: begin
            cmd.dp_op     = DP_MUL_HL;
            cmd.use_mul_b = 1'b1;
         end
         ST_MB_LH: begin
            cmd.dp_op     = DP_MUL_LH;
            cmd.use_mul_b = 1'b1;
         end
         ST_MB_SUM: begin
            cmd.dp_op     = DP_MUL_SUM;
            cmd.use_mul_b = 1'b1;
         end
         ST_FIN:    cmd.dp_op = DP_FINAL;
         ST_DIV: begin
            cmd.dp_op = stat.div_last ? DP_TAKE_REM : DP_DIV_STEP;
         end
         ST_REM: begin
            if (slot_free) begin
               cmd.dp_op = DP_PUBLISH;
               publish   = 1'b1;
            end
         end
         ST_CHECK:  cmd.dp_op = DP_NONE;
         default:   cmd.dp_op = DP_NONE;
      endcase
   end

   // Hold the result beat until the sink takes it
   assign rsp_valid_in = publish || (rsp_valid_ff && !rsp_tready);
   assign rsp_tvalid   = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: sv/smx_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smx_dpath
// Generator state, mixing operand, one shared 32x32 multiplier with an
// accumulator, a one-bit-per-cycle remainder unit and the result registers.
// ----------------------------------------------------------------------------
module smx_dpath
   import smx_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  smx_cmd_type         cmd,
   output smx_stat_type        stat,
   input  logic [1:0]          req_op,
   input  logic [WORD_W-1:0]   req_bound,
   input  logic [WORD_W-1:0]   seed,
   output logic [WORD_W-1:0]   rsp_value
);

   logic [WORD_W-1:0] gen_state_ff, gen_state_in;
   logic [WORD_W-1:0] z_ff, z_in;
   logic [WORD_W-1:0] acc_ff, acc_in;
   logic [WORD_W-1:0] prod_ff, prod_in;
   logic [WORD_W-1:0] rem_ff, rem_in;
   logic [WORD_W-1:0] dvd_ff, dvd_in;
   logic [WORD_W-1:0] res_ff, res_in;
   logic [WORD_W-1:0] out_ff, out_in;
   logic [WORD_W-1:0] bound_ff, bound_in;
   req_op_type        op_ff, op_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   logic [WORD_W-1:0] adv_state;
   logic [WORD_W-1:0] mul_k;
   logic [HALF_W-1:0] mul_x, mul_y;
   logic [WORD_W-1:0] mul_out;
   logic [WORD_W-1:0] acc_sum;
   logic [WORD_W-1:0] word;
   logic [WORD_W:0]   trial;
   logic [WORD_W:0]   trial_diff;

   // Status to the controller
   assign stat.op         = op_ff;
   assign stat.bound_zero = (bound_ff == '0);
   assign stat.div_last   = (cnt_ff == {CNT_W{1'b1}});

   assign adv_state = gen_state_ff + GOLDEN_INC;
   assign mul_k     = cmd.use_mul_b ? MIX_MUL_B : MIX_MUL_A;

   // Select operand halves for the partial product of this step
   always_comb begin
      mul_x = z_ff[HALF_W-1:0];
      mul_y = mul_k[HALF_W-1:0];
      case (cmd.dp_op)
         DP_MUL_HL: mul_x = z_ff[WORD_W-1:HALF_W];
         DP_MUL_LH: mul_y = mul_k[WORD_W-1:HALF_W];
         default: ;
      endcase
   end

   assign mul_out = {{HALF_W{1'b0}}, mul_x} * {{HALF_W{1'b0}}, mul_y};

   // Cross products only reach the upper half of the low 64 bits
   assign acc_sum = acc_ff + {prod_ff[HALF_W-1:0], {HALF_W{1'b0}}};

   // Final xor-shift of the mixed word
   assign word = acc_ff ^ (acc_ff >> 31);

   // Restoring remainder step
   assign trial      = {rem_ff, dvd_ff[WORD_W-1]};
   assign trial_diff = trial - {1'b0, bound_ff};

   always_comb begin
      gen_state_in = gen_state_ff;
      z_in         = z_ff;
      acc_in       = acc_ff;
      prod_in      = prod_ff;
      rem_in       = rem_ff;
      dvd_in       = dvd_ff;
      res_in       = res_ff;
      out_in       = out_ff;
      bound_in     = bound_ff;
      op_in        = op_ff;
      cnt_in       = cnt_ff;
      case (cmd.dp_op)
         DP_CAPTURE: begin
            op_in    = req_op_type'(req_op);
            bound_in = req_bound;
         end
         DP_ADVANCE: begin
            gen_state_in = adv_state;
            z_in         = adv_state ^ (adv_state >> 30);
         end
         DP_MUL_LL: prod_in = mul_out;
         DP_MUL_HL: begin
            acc_in  = prod_ff;
            prod_in = mul_out;
         end
         DP_MUL_LH: begin
            acc_in  = acc_sum;
            prod_in = mul_out;
         end
         DP_MUL_SUM: acc_in = acc_sum;
         DP_XSH27:   z_in   = acc_ff ^ (acc_ff >> 27);
         DP_FINAL: begin
            rem_in = '0;
            dvd_in = word;
            cnt_in = '0;
            case (op_ff)
               REQ_WORD:  res_in = word;
               REQ_UPPER: res_in = {{HALF_W{1'b0}}, word[WORD_W-1:HALF_W]};
               REQ_BOOL:  res_in = {{(WORD_W-1){1'b0}}, word[0]};
               default:   res_in = '0;
            endcase
         end
         DP_DIV_STEP, DP_TAKE_REM: begin
            // Subtract when the shifted remainder reaches the bound
            if (!trial_diff[WORD_W]) rem_in = trial_diff[WORD_W-1:0];
            else                     rem_in = trial[WORD_W-1:0];
            dvd_in = {dvd_ff[WORD_W-2:0], 1'b0};
            cnt_in = cnt_ff + 1'b1;
            if (cmd.dp_op == DP_TAKE_REM) res_in = rem_in;
         end
         DP_ZERO:    res_in = '0;
         DP_PUBLISH: out_in = res_ff;
         default: ;
      endcase
      // Seed write reloads the state; zero stands for the increment
      if (cmd.load_seed) gen_state_in = (seed != '0) ? seed : GOLDEN_INC;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gen_state_ff <= GOLDEN_INC;
      end else begin
         gen_state_ff <= gen_state_in;
      end
   end

   always_ff @(posedge clock) begin
      z_ff     <= z_in;
      acc_ff   <= acc_in;
      prod_ff  <= prod_in;
      rem_ff   <= rem_in;
      dvd_ff   <= dvd_in;
      res_ff   <= res_in;
      out_ff   <= out_in;
      bound_ff <= bound_in;
      op_ff    <= op_in;
      cnt_ff   <= cnt_in;
   end

   assign rsp_value = out_ff;

endmodule

FILE: sv/splitmix64_random_source.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// splitmix64_random_source
// SplitMix64 generator with a seed register and four request kinds.
// ----------------------------------------------------------------------------
// Each request beat advances the 64-bit state by the golden-ratio increment
// and mixes it into a random word, returned whole, as its upper 32 bits, as
// the word modulo a bound, or as bit 0. The time to the result beat is set
// by the two mixing multiplies on a single 32x32 multiplier (three partial
// products each) and, for the bounded kind, by the remainder unit, which
// resolves one bit per cycle. A bounded request with a zero bound offers 0
// without touching the state. A new request is taken only when the
// previous one has reached the output register, which holds its beat until
// the sink takes it. Writing the seed reloads the state; a zero seed loads
// the golden-ratio increment, which is also the reset state.
module splitmix64_random_source
   import smx_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // [1:0] op, [65:2] bound, [71:66] zero
   // Result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [63:0] value
   // Seed register write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [63:0] csr_data     // [63:0] seed_value
);

   smx_cmd_type  cmd;
   smx_stat_type stat;

   smx_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .cmd        (cmd),
      .stat       (stat)
   );

   smx_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_op    (req_tdata[1:0]),
      .req_bound (req_tdata[65:2]),
      .seed      (csr_data),
      .rsp_value (rsp_tdata)
   );

endmodule
